### rtl/ppd_pkg.sv
// Shared types, constants and helpers for the priority dispatcher.
package ppd_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PID_BITS    = 16;
	localparam int NUM_LEVELS  = 5;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LVL_W = $clog2(NUM_LEVELS);

	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int PORT_PID_W = 16;
	localparam int PORT_LVL_W = 3;

	localparam logic [KIND_W-1:0] K_ADD      = 2'd0;
	localparam logic [KIND_W-1:0] K_TERM     = 2'd1;
	localparam logic [KIND_W-1:0] K_REMOVE   = 2'd2;
	localparam logic [KIND_W-1:0] K_DISPATCH = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic [PID_BITS-1:0] pid_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [LVL_W-1:0]    lvl_t;

	typedef struct packed {
		logic push;
		logic pop;
		pid_t pid;
	} q_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		pid_t head;
	} q_stat_t;

	typedef struct packed {
		logic                running_valid;
		pid_t                running_pid;
		lvl_t                running_level;
		logic                switched;
		logic [STATUS_W-1:0] status;
	} res_t;

	function automatic ptr_t ptr_inc(input ptr_t ptr);
		ptr_t nxt;
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + 1'b1;
		end
		return nxt;
	endfunction

endpackage

### rtl/ppd_queue.sv
// One priority level's ready queue: a ring of task ids with head, tail and count.
module ppd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  ppd_pkg::q_cmd_t  cmd,
	output ppd_pkg::q_stat_t stat
);

	ppd_pkg::pid_t mem_q [ppd_pkg::QUEUE_DEPTH];
	ppd_pkg::ptr_t head_q;
	ppd_pkg::ptr_t tail_q;
	ppd_pkg::cnt_t count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q <= ppd_pkg::ptr_inc(tail_q);
			end
			if (cmd.pop) begin
				head_q <= ppd_pkg::ptr_inc(head_q);
			end
			count_q <= count_q + ppd_pkg::CNT_W'(cmd.push) - ppd_pkg::CNT_W'(cmd.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[tail_q] <= cmd.pid;
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == ppd_pkg::CNT_W'(ppd_pkg::QUEUE_DEPTH));
	assign stat.head  = mem_q[head_q];

endmodule

### rtl/ppd_dispatch.sv
// Running slot, highest-level pick and queue push/pop decisions for one event.
module ppd_dispatch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [ppd_pkg::KIND_W-1:0]    kind,
	input  ppd_pkg::pid_t                 pid,
	input  logic [ppd_pkg::PORT_LVL_W-1:0] prio,
	input  ppd_pkg::q_stat_t              stat [ppd_pkg::NUM_LEVELS],
	output ppd_pkg::q_cmd_t               cmd  [ppd_pkg::NUM_LEVELS],
	output ppd_pkg::res_t                 res
);

	logic          cur_valid_q;
	ppd_pkg::pid_t cur_pid_q;
	ppd_pkg::lvl_t cur_level_q;

	logic          any;
	ppd_pkg::lvl_t top;
	ppd_pkg::lvl_t add_lvl;
	logic          do_disp;
	logic          nv;
	ppd_pkg::pid_t np;
	ppd_pkg::lvl_t nl;
	logic          sw;
	logic [ppd_pkg::STATUS_W-1:0] st;

	always_comb begin
		any     = 1'b0;
		top     = '0;
		add_lvl = ppd_pkg::LVL_W'(prio);
		do_disp = 1'b0;
		nv      = cur_valid_q;
		np      = cur_pid_q;
		nl      = cur_level_q;
		sw      = 1'b0;
		st      = ppd_pkg::ST_OK;
		for (int i = 0; i < ppd_pkg::NUM_LEVELS; i++) begin
			cmd[i].push = 1'b0;
			cmd[i].pop  = 1'b0;
			cmd[i].pid  = pid;
			if (!stat[i].empty) begin
				any = 1'b1;
				top = ppd_pkg::LVL_W'(i);
			end
		end
		unique case (kind)
			ppd_pkg::K_ADD: begin
				if (int'(prio) < ppd_pkg::NUM_LEVELS) begin
					if (stat[add_lvl].full) begin
						st = ppd_pkg::ST_FULL;
					end else begin
						cmd[add_lvl].push = fire;
					end
				end
			end
			ppd_pkg::K_TERM: begin
				nv = 1'b0;
				np = '0;
				nl = '0;
			end
			ppd_pkg::K_REMOVE: begin
				nv      = 1'b0;
				np      = '0;
				nl      = '0;
				do_disp = 1'b1;
			end
			ppd_pkg::K_DISPATCH: begin
				do_disp = 1'b1;
			end
			default: begin
				do_disp = 1'b0;
			end
		endcase
		if (do_disp) begin
			if (!any) begin
				st = ppd_pkg::ST_EMPTY;
			end else if (nv && (nl >= top)) begin
				st = ppd_pkg::ST_OK;
			end else if (nv && stat[nl].full) begin
				st = ppd_pkg::ST_FULL;
			end else begin
				cmd[top].pop = fire;
				if (nv) begin
					cmd[nl].push = fire;
					cmd[nl].pid  = np;
				end
				np = stat[top].head;
				nl = top;
				nv = 1'b1;
				sw = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_pid_q   <= '0;
			cur_level_q <= '0;
		end else if (fire) begin
			cur_valid_q <= nv;
			cur_pid_q   <= np;
			cur_level_q <= nl;
		end
	end

	assign res.running_valid = nv;
	assign res.running_pid   = np;
	assign res.running_level = nl;
	assign res.switched      = sw;
	assign res.status        = st;

endmodule

### rtl/preemptive_priority_dispatcher_core.sv
// Top level: input register, dispatch logic over the level queues, result register.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid, in_ready   | kind, task_pid, task_priority
//  out     | output    | out_valid, out_ready | running_valid, running_pid, running_level,
//          |           |                      | switched, status
//
// One event per cycle sustained while results are taken. An accepted event moves from
// the input register into the result register once that register is free or its result
// is taken; the pick, pop and push over the level queues are combinational and set that rate.
// Reset empties all queues and the running slot; queue entries are not cleared.
// A stalled result holds the input register; in_ready drops only when both registers are
// full and the result is not taken in that cycle.
module preemptive_priority_dispatcher_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ppd_pkg::KIND_W-1:0]       kind,
	input  logic [ppd_pkg::PORT_PID_W-1:0]   task_pid,
	input  logic [ppd_pkg::PORT_LVL_W-1:0]   task_priority,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             running_valid,
	output logic [ppd_pkg::PORT_PID_W-1:0]   running_pid,
	output logic [ppd_pkg::PORT_LVL_W-1:0]   running_level,
	output logic                             switched,
	output logic [ppd_pkg::STATUS_W-1:0]     status
);

	logic                             valid_s1;
	logic [ppd_pkg::KIND_W-1:0]       kind_s1;
	ppd_pkg::pid_t                    pid_s1;
	logic [ppd_pkg::PORT_LVL_W-1:0]   prio_s1;
	logic                             out_valid_q;
	ppd_pkg::res_t                    res_q;
	ppd_pkg::res_t                    res;
	logic                             fire;
	ppd_pkg::q_cmd_t                  cmd  [ppd_pkg::NUM_LEVELS];
	ppd_pkg::q_stat_t                 stat [ppd_pkg::NUM_LEVELS];

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			pid_s1  <= ppd_pkg::PID_BITS'(task_pid);
			prio_s1 <= task_priority;
		end
	end

	for (genvar g = 0; g < ppd_pkg::NUM_LEVELS; g++) begin : g_lvl
		ppd_queue u_queue (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[g]),
			.stat   (stat[g])
		);
	end

	ppd_dispatch u_dispatch (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.kind   (kind_s1),
		.pid    (pid_s1),
		.prio   (prio_s1),
		.stat   (stat),
		.cmd    (cmd),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign running_valid = res_q.running_valid;
	assign running_pid   = ppd_pkg::PORT_PID_W'(res_q.running_pid);
	assign running_level = ppd_pkg::PORT_LVL_W'(res_q.running_level);
	assign switched      = res_q.switched;
	assign status        = res_q.status;

`ifndef SYNTH
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed beat did not produce a result");

	a_switch_runs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && switched |-> running_valid && (status == ppd_pkg::ST_OK))
		else $error("switch reported without a running task");

	a_empty_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running_valid |-> (running_pid == '0) && (running_level == '0))
		else $error("empty slot shows nonzero task");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");
`endif

endmodule

### dv/tb_preemptive_priority_dispatcher_core.sv
// Testbench for the preemptive priority dispatcher: directed and random event streams, scoreboard check.
module tb_preemptive_priority_dispatcher_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_EVENTS = 2000;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_AT_BEAT  = 700;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_FROM    = 1200;
	localparam int QUIET_TO      = 1800;
	localparam int IDLE_PCT      = 11;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [ppd_pkg::KIND_W-1:0]     kind;
		logic [ppd_pkg::PORT_PID_W-1:0] pid;
		logic [ppd_pkg::PORT_LVL_W-1:0] prio;
	} sched_event_t;

	typedef struct packed {
		logic                           valid;
		logic [ppd_pkg::PORT_PID_W-1:0] pid;
		logic [ppd_pkg::PORT_LVL_W-1:0] lvl;
		logic                           sw;
		logic [ppd_pkg::STATUS_W-1:0]   st;
	} sched_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [ppd_pkg::KIND_W-1:0]     kind = ppd_pkg::K_ADD;
	logic [ppd_pkg::PORT_PID_W-1:0] task_pid = '0;
	logic [ppd_pkg::PORT_LVL_W-1:0] task_priority = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           running_valid;
	logic [ppd_pkg::PORT_PID_W-1:0] running_pid;
	logic [ppd_pkg::PORT_LVL_W-1:0] running_level;
	logic                           switched;
	logic [ppd_pkg::STATUS_W-1:0]   status;

	sched_event_t  pending_events[$];
	sched_result_t expected_results[$];

	ppd_pkg::pid_t ready_pids [ppd_pkg::NUM_LEVELS][ppd_pkg::QUEUE_DEPTH];
	int            q_head [ppd_pkg::NUM_LEVELS] = '{default: 0};
	int            q_count [ppd_pkg::NUM_LEVELS] = '{default: 0};
	ppd_pkg::pid_t run_pid = '0;
	int            run_lvl = 0;
	logic          run_valid = 1'b0;

	bit           in_accepted = 1'b0;
	bit           out_accepted = 1'b0;
	int unsigned  cyc = 0;
	int unsigned  beats_in = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  mismatches = 0;
	int unsigned  hold_left = 0;
	bit           hold_done = 1'b0;
	bit           quiet;
	sched_event_t next_ev;

	preemptive_priority_dispatcher_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.task_pid      (task_pid),
		.task_priority (task_priority),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.running_valid (running_valid),
		.running_pid   (running_pid),
		.running_level (running_level),
		.switched      (switched),
		.status        (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

	function automatic void ready_push(input int lvl, input ppd_pkg::pid_t pid);
		ready_pids[lvl][(q_head[lvl] + q_count[lvl]) % ppd_pkg::QUEUE_DEPTH] = pid;
		q_count[lvl]++;
	endfunction

	function automatic logic [ppd_pkg::STATUS_W-1:0] sched_dispatch(output logic sw);
		int            top;
		ppd_pkg::pid_t nxt;
		sw = 1'b0;
		top = -1;
		for (int l = ppd_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
			if (top < 0 && q_count[l] != 0) begin
				top = l;
			end
		end
		if (top < 0) begin
			return ppd_pkg::ST_EMPTY;
		end
		if (run_valid && run_lvl >= top) begin
			return ppd_pkg::ST_OK;
		end
		if (run_valid && q_count[run_lvl] >= ppd_pkg::QUEUE_DEPTH) begin
			return ppd_pkg::ST_FULL;
		end
		nxt = ready_pids[top][q_head[top]];
		q_head[top] = (q_head[top] + 1) % ppd_pkg::QUEUE_DEPTH;
		q_count[top]--;
		if (run_valid) begin
			ready_push(run_lvl, run_pid);
		end
		run_pid = nxt;
		run_lvl = top;
		run_valid = 1'b1;
		sw = 1'b1;
		return ppd_pkg::ST_OK;
	endfunction

	function automatic sched_result_t sched_apply(input sched_event_t ev);
		sched_result_t                r;
		logic                         sw;
		logic [ppd_pkg::STATUS_W-1:0] st;
		sw = 1'b0;
		st = ppd_pkg::ST_OK;
		case (ev.kind)
			ppd_pkg::K_ADD: begin
				if (ev.prio < ppd_pkg::NUM_LEVELS) begin
					if (q_count[ev.prio] >= ppd_pkg::QUEUE_DEPTH) begin
						st = ppd_pkg::ST_FULL;
					end else begin
						ready_push(int'(ev.prio), ppd_pkg::pid_t'(ev.pid));
					end
				end
			end
			ppd_pkg::K_TERM, ppd_pkg::K_REMOVE: begin
				run_valid = 1'b0;
				run_pid = '0;
				run_lvl = 0;
				if (ev.kind == ppd_pkg::K_REMOVE) begin
					st = sched_dispatch(sw);
				end
			end
			default: begin
				st = sched_dispatch(sw);
			end
		endcase
		r.valid = run_valid;
		r.pid   = run_valid ? ppd_pkg::PORT_PID_W'(run_pid) : '0;
		r.lvl   = run_valid ? ppd_pkg::PORT_LVL_W'(run_lvl) : '0;
		r.sw    = sw;
		r.st    = st;
		return r;
	endfunction

	task automatic report_mismatch(input string why, input sched_result_t want,
			input sched_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch (%s) at cycle %0d", why, cyc);
			$display("  expected valid=%0d pid=%h level=%0d switched=%0d status=%0d",
				want.valid, want.pid, want.lvl, want.sw, want.st);
			$display("  actual   valid=%0d pid=%h level=%0d switched=%0d status=%0d",
				got.valid, got.pid, got.lvl, got.sw, got.st);
		end
	endtask

	task automatic queue_event(input logic [ppd_pkg::KIND_W-1:0] k,
			input logic [ppd_pkg::PORT_PID_W-1:0] pid,
			input logic [ppd_pkg::PORT_LVL_W-1:0] prio);
		sched_event_t ev;
		ev.kind = k;
		ev.pid  = pid;
		ev.prio = prio;
		pending_events.insert(pending_events.size(), ev);
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_accepted) begin
			if (pending_events.size() == 0 || (!quiet && $urandom_range(99) < IDLE_PCT)) begin
				in_valid <= 1'b0;
			end else begin
				next_ev = pending_events[0];
				pending_events.delete(0);
				kind          <= next_ev.kind;
				task_pid      <= next_ev.pid;
				task_priority <= next_ev.prio;
				in_valid      <= 1'b1;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin : mon
		sched_result_t want;
		sched_result_t got;
		cyc++;
		in_accepted  = arst_n && in_valid && in_ready;
		out_accepted = arst_n && out_valid && out_ready;
		if (out_accepted) begin
			got = {running_valid, running_pid, running_level, switched, status};
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", '0, got);
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (got.valid !== want.valid || got.pid !== want.pid || got.lvl !== want.lvl
						|| got.sw !== want.sw || got.st !== want.st) begin
					report_mismatch("wrong field", want, got);
				end
			end
		end
		if (in_accepted) begin
			expected_results.insert(expected_results.size(),
				sched_apply(sched_event_t'({kind, task_pid, task_priority})));
			beats_in++;
		end
		if (in_accepted || out_accepted) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL preemptive_priority_dispatcher_core");
			$finish;
		end
	end

	initial begin : stim
		sched_event_t ev;
		int counted;
		int blk;
		int mode;
		int focus;
		int add_pct;
		int r;

		queue_event(ppd_pkg::K_DISPATCH, 16'h1234, 3'd0);
		queue_event(ppd_pkg::K_TERM, 16'h0000, 3'd7);
		queue_event(ppd_pkg::K_REMOVE, 16'hffff, 3'd0);
		queue_event(ppd_pkg::K_ADD, 16'h0000, 3'd0);
		queue_event(ppd_pkg::K_DISPATCH, 16'h0000, 3'd0);
		queue_event(ppd_pkg::K_ADD, 16'hffff, 3'd0);
		repeat (ppd_pkg::QUEUE_DEPTH - 1) begin
			queue_event(ppd_pkg::K_ADD, ppd_pkg::PORT_PID_W'($urandom), 3'd0);
		end
		queue_event(ppd_pkg::K_ADD, 16'hbeef, 3'd0);
		queue_event(ppd_pkg::K_ADD, 16'h5a5a, 3'd3);
		queue_event(ppd_pkg::K_DISPATCH, 16'h0000, 3'd0);
		queue_event(ppd_pkg::K_ADD, 16'hffff, 3'd7);
		queue_event(ppd_pkg::K_TERM, 16'h0000, 3'd0);
		queue_event(ppd_pkg::K_REMOVE, 16'h0000, 3'd0);
		queue_event(ppd_pkg::K_ADD, 16'hffff, 3'd4);
		queue_event(ppd_pkg::K_DISPATCH, 16'h0000, 3'd0);
		queue_event(ppd_pkg::K_DISPATCH, 16'hffff, 3'd7);

		counted = 0;
		blk = 0;
		mode = 0;
		focus = 0;
		add_pct = 45;
		while (counted < RANDOM_EVENTS) begin
			if (blk == 0) begin
				blk = 64;
				mode = $urandom_range(3);
				focus = $urandom_range(ppd_pkg::NUM_LEVELS - 1);
				add_pct = (mode == 0) ? 45 : (mode == 1) ? 80 : (mode == 2) ? 15 : 55;
			end
			blk--;
			ev.pid = ppd_pkg::PORT_PID_W'($urandom);
			ev.prio = ppd_pkg::PORT_LVL_W'($urandom_range(7));
			if ($urandom_range(99) < add_pct) begin
				ev.kind = ppd_pkg::K_ADD;
				if ($urandom_range(19) == 0) begin
					ev.prio = ppd_pkg::PORT_LVL_W'($urandom_range(7, ppd_pkg::NUM_LEVELS));
				end else if (mode == 1 && $urandom_range(9) < 7) begin
					ev.prio = ppd_pkg::PORT_LVL_W'(focus);
				end else begin
					ev.prio = ppd_pkg::PORT_LVL_W'($urandom_range(ppd_pkg::NUM_LEVELS - 1));
				end
			end else begin
				r = $urandom_range(9);
				ev.kind = (r < 2) ? ppd_pkg::K_TERM :
					(r < 5) ? ppd_pkg::K_REMOVE : ppd_pkg::K_DISPATCH;
			end
			pending_events.insert(pending_events.size(), ev);
			if (!(ev.kind == ppd_pkg::K_ADD && ev.prio >= ppd_pkg::NUM_LEVELS)) begin
				counted++;
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (8) @(negedge clk);

		if (mismatches == 0) begin
			$display("PASS preemptive_priority_dispatcher_core");
		end else begin
			$display("FAIL preemptive_priority_dispatcher_core");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/ppd_pkg.sv
rtl/ppd_queue.sv
rtl/ppd_dispatch.sv
rtl/preemptive_priority_dispatcher_core.sv
dv/tb_preemptive_priority_dispatcher_core.sv
